>>> src/crpt_pkg.sv
`default_nettype none
package crpt_pkg;

  localparam int MAX_BUFFER_BYTES_DEF = 65536;

  localparam int CMD_W     = 3;
  localparam int HW_PTR_W  = 17;
  localparam int REQ_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;
  localparam int CNT_W     = 32;
  localparam int OFF_W     = 16;
  localparam int LEN_W     = 17;

  localparam logic [CFG_DAT_W-1:0] BUFFER_SIZE_RST = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_POINTER = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_CONSUME = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_SIZE = 2'd0,
    REG_EIGHT_BIT   = 2'd1,
    REG_MMAP        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic eight_bit;
    logic mmap;
  } cfg_mode_t;

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic [OFF_W-1:0] first_offset;
    logic [LEN_W-1:0] first_length;
    logic [LEN_W-1:0] second_length;
    logic             overrun;
    logic [CNT_W-1:0] total_count;
    logic             running;
  } result_t;

endpackage
`default_nettype wire

>>> src/crpt_cfg_if.sv
`default_nettype none
interface crpt_cfg_if;
  import crpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/crpt_in_if.sv
`default_nettype none
interface crpt_in_if;
  import crpt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HW_PTR_W-1:0] hw_pointer;
  logic [REQ_W-1:0]    request_size;

  modport source (output valid, output command, output hw_pointer, output request_size,
                  input ready);
  modport sink (input valid, input command, input hw_pointer, input request_size,
                output ready);
endinterface
`default_nettype wire

>>> src/crpt_out_if.sv
`default_nettype none
interface crpt_out_if;
  import crpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] byte_count;
  logic [OFF_W-1:0] first_offset;
  logic [LEN_W-1:0] first_length;
  logic [LEN_W-1:0] second_length;
  logic             overrun;
  logic [CNT_W-1:0] total_count;
  logic             running;

  modport source (output valid, output byte_count, output first_offset, output first_length,
                  output second_length, output overrun, output total_count, output running,
                  input ready);
  modport sink (input valid, input byte_count, input first_offset, input first_length,
                input second_length, input overrun, input total_count, input running,
                output ready);
endinterface
`default_nettype wire

>>> src/crpt_cfg_regs.sv
`default_nettype none
module crpt_cfg_regs #(
  parameter int MAX_BUFFER_BYTES = crpt_pkg::MAX_BUFFER_BYTES_DEF,
  parameter int SIZE_W           = $clog2(MAX_BUFFER_BYTES + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  crpt_cfg_if.sink                 cfg,
  output logic [SIZE_W-1:0]        size,
  output crpt_pkg::cfg_mode_t      mode
);
  import crpt_pkg::*;

  logic [CFG_DAT_W-1:0] buffer_size;
  logic                 size_zero;
  logic                 size_over;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size    <= BUFFER_SIZE_RST;
      mode.eight_bit <= 1'b0;
      mode.mmap      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_BUFFER_SIZE: buffer_size    <= cfg.data;
        REG_EIGHT_BIT:   mode.eight_bit <= cfg.data[0];
        REG_MMAP:        mode.mmap      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the ring limit
  assign size_zero = (buffer_size == '0);
  assign size_over = (32'(buffer_size) > 32'(MAX_BUFFER_BYTES));

  always_comb begin
    if (size_zero) begin
      size = SIZE_W'(1);
    end else if (size_over) begin
      size = SIZE_W'(MAX_BUFFER_BYTES);
    end else begin
      size = SIZE_W'(buffer_size);
    end
  end
endmodule
`default_nettype wire

>>> src/crpt_datapath.sv
`default_nettype none
module crpt_datapath #(
  parameter int POS_W  = 16,
  parameter int SIZE_W = 17
) (
  input  wire crpt_pkg::cmd_t                 command,
  input  wire logic [crpt_pkg::HW_PTR_W-1:0]  hw_pointer,
  input  wire logic [crpt_pkg::REQ_W-1:0]     request_size,
  input  wire logic [SIZE_W-1:0]              size,
  input  wire crpt_pkg::cfg_mode_t            mode,
  input  wire logic [POS_W-1:0]               last_pos,
  input  wire logic [POS_W-1:0]               read_pos,
  input  wire logic [crpt_pkg::CNT_W-1:0]     pending,
  input  wire logic [crpt_pkg::CNT_W-1:0]     total,
  input  wire logic                           running,
  output logic [POS_W-1:0]                    last_pos_next,
  output logic [POS_W-1:0]                    read_pos_next,
  output logic [crpt_pkg::CNT_W-1:0]          pending_next,
  output logic [crpt_pkg::CNT_W-1:0]          total_next,
  output logic                                running_next,
  output crpt_pkg::result_t                   res
);
  import crpt_pkg::*;

  localparam int CMP_W = (SIZE_W > HW_PTR_W) ? SIZE_W : HW_PTR_W;
  localparam int SUM_W = SIZE_W + 1;

  logic [HW_PTR_W-1:0] hw_sel;
  logic                hw_ok;
  logic [POS_W-1:0]    hw_pos;
  logic [POS_W-1:0]    last_eff;
  logic [SUM_W-1:0]    diff_raw;
  logic [SIZE_W-1:0]   diff;
  logic [CNT_W:0]      pend_sum;
  logic [SIZE_W-1:0]   grant;
  logic [POS_W-1:0]    start;
  logic [SIZE_W-1:0]   room;
  logic [SUM_W-1:0]    pos_raw;
  logic [POS_W-1:0]    pos_wrap;
  logic                overrun_hit;

  // pointer update
  assign hw_sel   = mode.eight_bit ? (hw_pointer >> 1) : hw_pointer;
  assign hw_ok    = (CMP_W'(hw_sel) < CMP_W'(size));
  assign hw_pos   = POS_W'(hw_sel);
  assign last_eff = (SIZE_W'(last_pos) < size) ? last_pos : '0;
  assign diff_raw = SUM_W'(size) + SUM_W'(hw_pos) - SUM_W'(last_eff);
  assign diff     = (diff_raw >= SUM_W'(size)) ? SIZE_W'(diff_raw - SUM_W'(size))
                                               : SIZE_W'(diff_raw);
  assign pend_sum = {1'b0, pending} + (CNT_W + 1)'(diff);

  // consume
  assign grant    = (CMP_W'(request_size) < CMP_W'(size)) ? SIZE_W'(request_size) : size;
  assign start    = (SIZE_W'(read_pos) < size) ? read_pos : '0;
  assign room     = size - SIZE_W'(start);
  assign pos_raw  = SUM_W'(start) + SUM_W'(grant);
  assign pos_wrap = (pos_raw >= SUM_W'(size)) ? POS_W'(pos_raw - SUM_W'(size))
                                             : POS_W'(pos_raw);

  // query
  assign overrun_hit = !mode.mmap && (pending > CNT_W'(size));

  always_comb begin
    last_pos_next = last_pos;
    read_pos_next = read_pos;
    pending_next  = pending;
    total_next    = total;
    running_next  = running;
    res           = '0;

    unique case (command)
      CMD_START: begin
        last_pos_next = '0;
        read_pos_next = '0;
        pending_next  = '0;
        running_next  = 1'b1;
      end
      CMD_STOP: begin
        running_next = 1'b0;
      end
      CMD_POINTER: begin
        if (running && hw_ok) begin
          total_next    = total + CNT_W'(diff);
          pending_next  = pend_sum[CNT_W] ? '1 : pend_sum[CNT_W-1:0];
          last_pos_next = hw_pos;
        end
      end
      CMD_QUERY: begin
        res.byte_count = pending;
        if (overrun_hit) begin
          res.byte_count = CNT_W'(size);
          res.overrun    = 1'b1;
          read_pos_next  = last_pos;
          pending_next   = CNT_W'(size);
        end
      end
      CMD_CONSUME: begin
        res.byte_count   = CNT_W'(grant);
        res.first_offset = OFF_W'(start);
        if (grant > room) begin
          res.first_length  = LEN_W'(room);
          res.second_length = LEN_W'(grant - room);
        end else begin
          res.first_length = LEN_W'(grant);
        end
        if (grant != '0) begin
          read_pos_next = pos_wrap;
          pending_next  = (pending > CNT_W'(grant)) ? pending - CNT_W'(grant) : '0;
        end
      end
      default: ;
    endcase

    res.total_count = total_next;
    res.running     = running_next;
  end
endmodule
`default_nettype wire

>>> src/capture_ring_pointer_tracker_top.sv
`default_nettype none
// Capture ring pointer tracker. Each request on cmd (start, stop, pointer update, query,
// consume) produces exactly one result on rsp. A request is registered in the input stage,
// then executed against the ring state and written to the result register; one request
// per cycle is accepted while rsp is ready, and the limit is the read-modify-write of
// the pending count and positions. The input stage keeps accepting while a result waits,
// and stalls only when both the input stage and the result register are occupied. The
// cfg port is always ready; registers (0 buffer_size, 1 eight_bit_mode, 2 mmap_mode)
// must only be written while no request is in flight. MAX_BUFFER_BYTES bounds the ring
// size and sets the width of the stored positions.
module capture_ring_pointer_tracker_top #(
  parameter int MAX_BUFFER_BYTES = crpt_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  crpt_cfg_if.sink  cfg,
  crpt_in_if.sink   cmd,
  crpt_out_if.source rsp
);
  import crpt_pkg::*;

  localparam int POS_W  = $clog2(MAX_BUFFER_BYTES);
  localparam int SIZE_W = $clog2(MAX_BUFFER_BYTES + 1);

  logic [SIZE_W-1:0]   size;
  cfg_mode_t           mode;

  logic                s1_valid;
  cmd_t                s1_command;
  logic [HW_PTR_W-1:0] s1_hw_pointer;
  logic [REQ_W-1:0]    s1_request_size;
  logic                advance;

  logic [POS_W-1:0]    last_pos;
  logic [POS_W-1:0]    read_pos;
  logic [CNT_W-1:0]    pending;
  logic [CNT_W-1:0]    total;
  logic                capture_running;
  logic [POS_W-1:0]    last_pos_next;
  logic [POS_W-1:0]    read_pos_next;
  logic [CNT_W-1:0]    pending_next;
  logic [CNT_W-1:0]    total_next;
  logic                running_next;

  result_t             res_next;
  result_t             res;
  logic                res_valid;

  crpt_cfg_regs #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
    .SIZE_W          (SIZE_W)
  ) u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .size(size),
    .mode(mode)
  );

  assign advance   = s1_valid && (!res_valid || rsp.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_command      <= cmd_t'(cmd.command);
      s1_hw_pointer   <= cmd.hw_pointer;
      s1_request_size <= cmd.request_size;
    end
  end

  crpt_datapath #(
    .POS_W (POS_W),
    .SIZE_W(SIZE_W)
  ) u_dp (
    .command      (s1_command),
    .hw_pointer   (s1_hw_pointer),
    .request_size (s1_request_size),
    .size         (size),
    .mode         (mode),
    .last_pos     (last_pos),
    .read_pos     (read_pos),
    .pending      (pending),
    .total        (total),
    .running      (capture_running),
    .last_pos_next(last_pos_next),
    .read_pos_next(read_pos_next),
    .pending_next (pending_next),
    .total_next   (total_next),
    .running_next (running_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos        <= '0;
      read_pos        <= '0;
      pending         <= '0;
      total           <= '0;
      capture_running <= 1'b0;
    end else if (advance) begin
      last_pos        <= last_pos_next;
      read_pos        <= read_pos_next;
      pending         <= pending_next;
      total           <= total_next;
      capture_running <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.byte_count    = res.byte_count;
  assign rsp.first_offset  = res.first_offset;
  assign rsp.first_length  = res.first_length;
  assign rsp.second_length = res.second_length;
  assign rsp.overrun       = res.overrun;
  assign rsp.total_count   = res.total_count;
  assign rsp.running       = res.running;

`ifndef SYNTHESIS
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_START) |=> capture_running && (pending == '0))
    else $error("start did not set running or clear pending");

  a_query_clamps: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_QUERY) && !mode.mmap |=> pending <= CNT_W'(size))
    else $error("pending above size after clamping query");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !rsp.ready |-> !cmd.ready)
    else $error("input accepted while pipeline is full");

  a_running_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid && (rsp.running == capture_running) && (rsp.total_count == total))
    else $error("result does not reflect state after request");
`endif
endmodule
`default_nettype wire
